### src/cpa_pkg.sv
// Shared types and constants for the contiguous page allocator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cpa_pkg;

	// Default sizing of the page table and of one page.
	localparam int unsigned MAX_PAGES_DEF  = 256;
	localparam int unsigned PAGE_BYTES_DEF = 4096;

	// Field widths fixed by the interface.
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned ZONE_W     = 9;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned INDEX_W    = 8;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned REF_W      = 8;

	localparam logic [ZONE_W-1:0] ZONE_RESET = 9'd256;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZONE_PAGES   = 4'd0,
		REG_BASE_ADDRESS = 4'd1
	} cfg_reg_t;

	// Request functions.
	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OOM      = 2'd1,
		STAT_BAD_FREE = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC,
		ST_SCAN,
		ST_MSTART,
		ST_MARK,
		ST_MUL,
		ST_ADD,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_RESULT
	} state_t;

	// One request as it arrives.
	typedef struct packed {
		logic               func;
		logic [COUNT_W-1:0] page_count;
		logic [INDEX_W-1:0] page_index;
	} req_t;

	// One finished result.
	typedef struct packed {
		logic [1:0]         status;
		logic [INDEX_W-1:0] start_index;
		logic [ADDR_W-1:0]  start_address;
		logic               page_released;
	} res_t;

endpackage

`default_nettype wire

### src/cpa_ref_store.sv
// Reference-count memory: one write port and one read port with registered data.
// Depends on cpa_pkg for the count width.
`default_nettype none

module cpa_ref_store
	import cpa_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_PAGES_DEF,
	parameter int unsigned AW    = $clog2(MAX_PAGES_DEF)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [REF_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [REF_W-1:0] rd_data
);

	logic [REF_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data appears the cycle after the address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### src/cpa_seq.sv
// Sequencer and shared adder for the allocator: clearing pass, first-fit scan,
// run marking, free and address forming. Depends on cpa_pkg and cpa_ref_store.
`default_nettype none

module cpa_seq
	import cpa_pkg::*;
#(
	parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
	parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF,
	parameter int unsigned AW         = $clog2(MAX_PAGES),
	parameter int unsigned ZW         = ((AW + 1) > ZONE_W) ? (AW + 1) : ZONE_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ZW-1:0]     zone_eff,
	input  wire logic [ADDR_W-1:0] base_addr,
	input  wire logic              req_go,
	input  wire req_t              req,
	output logic                   idle,
	output logic                   res_vld,
	input  wire logic              res_take,
	output res_t                   res
);

	localparam logic [ADDR_W-1:0] PAGE_W   = ADDR_W'(PAGE_BYTES);
	localparam logic [AW-1:0]     LAST_IDX = AW'(MAX_PAGES - 1);

	state_t state_q, state_d;

	req_t             req_q;
	logic [ZW-1:0]    scan_q;
	logic [ZW-1:0]    run_q;
	logic [ZW-1:0]    cnt_m1_q;
	logic [AW-1:0]    end_q;
	logic [AW-1:0]    mark_q;
	logic             chk_vld_s1;
	logic [AW-1:0]    chk_idx_s1;
	logic [ADDR_W-1:0] prod_q;

	logic [1:0]         status_q;
	logic [INDEX_W-1:0] sidx_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               rel_q;

	// Shared adder operands.
	logic [ADDR_W-1:0] alu_a, alu_b, alu_sum;
	logic              alu_sub;

	// Memory controls.
	logic             mem_wr_en, mem_rd_en;
	logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
	logic [REF_W-1:0] mem_wr_data, mem_rd_data;

	logic scan_issue, page_free, run_found, alloc_reject, free_reject;

	cpa_ref_store #(
		.DEPTH (MAX_PAGES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// The adder/subtractor shared by the allocate, scan, marking, address and free steps.
	assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ADDR_W'(alu_sub);

	assign scan_issue   = scan_q < zone_eff;
	assign page_free    = mem_rd_data == '0;
	assign run_found    = chk_vld_s1 && page_free && (run_q == cnt_m1_q);
	assign alloc_reject = (req_q.page_count == '0) || (ZW'(req_q.page_count) > zone_eff);
	assign free_reject  = ZW'(req_q.page_index) >= zone_eff;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and adder operand selection.
	always_comb begin
		state_d     = state_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = mark_q;
		mem_wr_data = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(scan_q);
		alu_a       = '0;
		alu_b       = ADDR_W'(1);
		alu_sub     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
				if (mark_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_go) begin
					state_d = (req.func == FUNC_FREE) ? ST_FREE_RD : ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				alu_a   = ADDR_W'(req_q.page_count);
				alu_sub = 1'b1;
				state_d = alloc_reject ? ST_RESULT : ST_SCAN;
			end
			ST_SCAN: begin
				mem_rd_en = scan_issue;
				alu_a     = ADDR_W'(run_q);
				if (run_found) begin
					state_d = ST_MSTART;
				end else if (!chk_vld_s1 && !scan_issue) begin
					state_d = ST_RESULT;
				end
			end
			ST_MSTART: begin
				alu_a   = ADDR_W'(end_q);
				alu_b   = ADDR_W'(cnt_m1_q);
				alu_sub = 1'b1;
				state_d = ST_MARK;
			end
			ST_MARK: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = REF_W'(1);
				alu_a       = ADDR_W'(mark_q);
				if (mark_q == end_q) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				alu_a   = base_addr;
				alu_b   = prod_q;
				state_d = ST_RESULT;
			end
			ST_FREE_RD: begin
				mem_rd_en   = !free_reject;
				mem_rd_addr = AW'(req_q.page_index);
				state_d     = free_reject ? ST_RESULT : ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				alu_a       = ADDR_W'(mem_rd_data);
				alu_sub     = 1'b1;
				mem_wr_addr = AW'(req_q.page_index);
				mem_wr_data = alu_sum[REF_W-1:0];
				mem_wr_en   = !page_free;
				state_d     = ST_RESULT;
			end
			ST_RESULT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: clear/mark counter and scan pipeline valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q     <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == ST_SCAN) && scan_issue && !run_found;
			unique case (state_q)
				ST_CLEAR:  mark_q <= mark_q + AW'(1);
				ST_MSTART: mark_q <= AW'(alu_sum);
				ST_MARK:   mark_q <= AW'(alu_sum);
				default:   mark_q <= mark_q;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		chk_idx_s1 <= AW'(scan_q);
		unique case (state_q)
			ST_IDLE: begin
				if (req_go) begin
					req_q    <= req;
					status_q <= STAT_OK;
					sidx_q   <= '0;
					addr_q   <= '0;
					rel_q    <= 1'b0;
				end
			end
			ST_ALLOC: begin
				cnt_m1_q <= ZW'(alu_sum);
				scan_q   <= '0;
				run_q    <= '0;
				if (alloc_reject) begin
					status_q <= STAT_OOM;
				end
			end
			ST_SCAN: begin
				if (scan_issue) begin
					scan_q <= scan_q + ZW'(1);
				end
				if (chk_vld_s1) begin
					run_q <= page_free ? ZW'(alu_sum) : '0;
				end
				if (run_found) begin
					end_q <= chk_idx_s1;
				end else if (!chk_vld_s1 && !scan_issue) begin
					status_q <= STAT_OOM;
				end
			end
			ST_MSTART: begin
				sidx_q <= INDEX_W'(alu_sum);
			end
			ST_MUL: begin
				prod_q <= ADDR_W'({{(ADDR_W-INDEX_W){1'b0}}, sidx_q} * PAGE_W);
			end
			ST_ADD: begin
				addr_q <= alu_sum;
			end
			ST_FREE_RD: begin
				if (free_reject) begin
					status_q <= STAT_BAD_FREE;
				end
			end
			ST_FREE_CHK: begin
				if (page_free) begin
					status_q <= STAT_BAD_FREE;
				end else begin
					rel_q <= alu_sum[REF_W-1:0] == '0;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign idle    = state_q == ST_IDLE;
	assign res_vld = state_q == ST_RESULT;

	always_comb begin
		res.status        = status_q;
		res.start_index   = sidx_q;
		res.start_address = addr_q;
		res.page_released = rel_q;
	end

	// The memory never reads and writes in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr_en && mem_rd_en))
		else $error("page count memory read and written together");

	// Marking writes stay inside the zone.
	a_mark_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (ZW'(mark_q) < zone_eff))
		else $error("run marking beyond zone end");

	// Every checked scan page lies inside the zone.
	a_scan_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (ZW'(chk_idx_s1) < zone_eff))
		else $error("scan checked a page beyond zone end");

	// A delivered result returns the sequencer to idle.
	a_result_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && res_take) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after result");

endmodule

`default_nettype wire

### src/contiguous_page_allocator.sv
// Allocate: after acceptance the page counts are scanned first-fit, one page a cycle, then
// the pages of a found run are marked, then the address is formed. Free: the page's count is
// read, then checked and decremented. One request at a time; the next can be taken in the
// cycle after the result enters the output register. After reset a clearing pass zeroes
// every count; no request is taken meanwhile, configuration writes are taken at any time.
// Top level: configuration registers, output register; uses cpa_pkg and cpa_seq.
`default_nettype none

module contiguous_page_allocator
	import cpa_pkg::*;
#(
	parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
	parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write channel.
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Request channel.
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  func,
	input  wire logic [COUNT_W-1:0]    page_count,
	input  wire logic [INDEX_W-1:0]    page_index,
	// Result channel.
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic [INDEX_W-1:0]         start_index,
	output logic [ADDR_W-1:0]          start_address,
	output logic                       page_released
);

	localparam int unsigned AW = $clog2(MAX_PAGES);
	localparam int unsigned ZW = ((AW + 1) > ZONE_W) ? (AW + 1) : ZONE_W;
	localparam logic [ZW-1:0] MAX_Z = ZW'(MAX_PAGES);

	logic [ZONE_W-1:0] zone_q;
	logic [ADDR_W-1:0] base_q;
	logic [ZW-1:0]     zone_eff;
	logic              seq_idle, res_vld, res_take, req_go;
	req_t              req;
	res_t              res, out_q;
	logic              out_valid_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
			base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ZONE_PAGES:   zone_q <= cfg_data[ZONE_W-1:0];
				REG_BASE_ADDRESS: base_q <= cfg_data[ADDR_W-1:0];
				default: begin
					zone_q <= zone_q;
				end
			endcase
		end
	end

	// Zone sizes above the table depth act as the table depth.
	assign zone_eff = (ZW'(zone_q) > MAX_Z) ? MAX_Z : ZW'(zone_q);

	// Request hand-off into the sequencer.
	assign in_stall = !seq_idle;
	assign req_go   = in_valid && !in_stall;

	always_comb begin
		req.func       = func;
		req.page_count = page_count;
		req.page_index = page_index;
	end

	cpa_seq #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES),
		.AW         (AW),
		.ZW         (ZW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.zone_eff  (zone_eff),
		.base_addr (base_q),
		.req_go    (req_go),
		.req       (req),
		.idle      (seq_idle),
		.res_vld   (res_vld),
		.res_take  (res_take),
		.res       (res)
	);

	// Output register: a finished result waits here until it is taken.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_vld && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign start_index   = out_q.start_index;
	assign start_address = out_q.start_address;
	assign page_released = out_q.page_released;

endmodule

`default_nettype wire
